// File: design/dvbetd_pkg.sv
// Shared types, constants and helper functions for the broadcast event time decoder.
// Used by every module of the decoder; depends on nothing else.
package dvbetd_pkg;

  // Date conversion constants, MJD formulas scaled to exact integers.
  localparam int MjdFloor   = 15079;   // earlier dates saturate here
  localparam int YearNumOfs = 301564;  // 20 * 15078.2
  localparam int YearRecip  = 587949;  // ceil(2^32 / 7305), exact for all numerators here
  localparam int YearShift  = 32;
  localparam int MjdOfs     = 14956;
  localparam int YearBase   = 1900;
  localparam int MonthScale = 306001;  // 30.6001 scaled by 10000
  localparam int MonthDen   = 10000;
  localparam int MonthBias  = 1000;    // the 0.1 of 14956.1, scaled

  // Widths of internal values.
  localparam int NumW  = 20;  // 20*mjd - 301564
  localparam int ProdW = NumW + YearShift - 12;  // product of NumW x 20-bit recip
  localparam int YpW   = 8;   // years since 1900, 0..138
  localparam int RW    = 10;  // days since the year start used by the month step
  localparam int MpW   = 5;   // month index M'
  localparam int MpN   = 1 << MpW;

  typedef logic [MpN-1:0][RW-1:0] mtab_t;

  // Decoded time-of-day and duration bytes.
  typedef struct packed {
    logic [7:0] start_hour;
    logic [7:0] start_minute;
    logic [7:0] start_second;
    logic [7:0] span_hours;
    logic [7:0] span_minutes;
    logic [7:0] span_seconds;
  } tod_t;

  // Stage one: saturated date and scaled year numerator.
  typedef struct packed {
    logic [15:0]     mjd;
    logic [NumW-1:0] num;
    tod_t            tod;
  } prep_t;

  // Stage two: year index known.
  typedef struct packed {
    logic [15:0]    mjd;
    logic [YpW-1:0] yp;
    tod_t           tod;
  } yidx_t;

  // Stage three: remainder of days inside the year.
  typedef struct packed {
    logic [YpW-1:0] yp;
    logic [RW-1:0]  r;
    tod_t           tod;
  } yrem_t;

  // Stage four: month index known.
  typedef struct packed {
    logic [YpW-1:0] yp;
    logic [RW-1:0]  r;
    logic [MpW-1:0] mp;
    tod_t           tod;
  } midx_t;

  // Final result.
  typedef struct packed {
    logic [10:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    tod_t        tod;
  } res_t;

  // Packed BCD byte to binary, high digit times ten plus low digit, no digit check.
  function automatic logic [7:0] bcd_dec(input logic [7:0] b);
    logic [7:0] hi;
    hi = {4'b0, b[7:4]};
    return (hi << 3) + (hi << 1) + {4'b0, b[3:0]};
  endfunction

  // Days covered by M' months: floor(M' * 30.6001), built at elaboration.
  function automatic mtab_t mk_mdays();
    mtab_t t;
    for (int i = 0; i < MpN; i++) begin
      t[i] = RW'((i * MonthScale) / MonthDen);
    end
    return t;
  endfunction

  // Smallest remainder with M' >= i, built at elaboration.
  function automatic mtab_t mk_mthr();
    mtab_t t;
    for (int i = 0; i < MpN; i++) begin
      t[i] = RW'((i * MonthScale + MonthBias + MonthDen - 1) / MonthDen);
    end
    return t;
  endfunction

endpackage

// File: design/dvb_event_time_decode_core.sv
// Broadcast event time decoder, top level: stream ports and pipeline assembly.
// Depends on dvbetd_pkg, dvbetd_prep, dvbetd_year and dvbetd_month.
//
// Takes one event start time (16-bit MJD plus BCD hour, minute, second) and one
// BCD duration per transfer and returns calendar year, month and day with the
// decoded time bytes. The decoder is a five-stage pipeline with a valid bit per
// stage: while the output is not stalled, one transfer is accepted per cycle
// and the rate is one item per clock. Every stage has its own ready, so a
// stalled output only holds the stages that are full. Dates below MJD 15079
// are clamped to it; BCD digits are not checked (values up to 165).
// The depth is set by the year step, a 20 x 20-bit reciprocal multiply that
// takes a stage on its own. There is no stored state and no startup sequence.
module dvb_event_time_decode_core
  import dvbetd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [39:0] event_start, [63:40] duration
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [10:0] year, [14:11] month, [19:15] day, [27:20] start_hour,
  // [35:28] start_minute, [43:36] start_second, [51:44] span_hours,
  // [59:52] span_minutes, [67:60] span_seconds, [71:68] zero
  output logic [71:0] m_axis_tdata
);

  logic  prep_vld;
  logic  prep_rdy;
  prep_t prep_data;
  logic  yr_vld;
  logic  yr_rdy;
  yrem_t yr_data;
  res_t  res;

  dvbetd_prep u_prep (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .event_start (s_axis_tdata[39:0]),
    .duration    (s_axis_tdata[63:40]),
    .out_valid   (prep_vld),
    .out_ready   (prep_rdy),
    .out_data    (prep_data)
  );

  dvbetd_year u_year (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_vld),
    .in_ready  (prep_rdy),
    .in_data   (prep_data),
    .out_valid (yr_vld),
    .out_ready (yr_rdy),
    .out_data  (yr_data)
  );

  dvbetd_month u_month (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (yr_vld),
    .in_ready  (yr_rdy),
    .in_data   (yr_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (res)
  );

  // Output packing, first field in the lowest bits.
  assign m_axis_tdata = {4'b0,
                         res.tod.span_seconds, res.tod.span_minutes, res.tod.span_hours,
                         res.tod.start_second, res.tod.start_minute, res.tod.start_hour,
                         res.day, res.month, res.year};

  // An accepted transfer always occupies the first stage on the next cycle.
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> prep_vld)
    else $error("accepted transfer did not enter the first stage");

  // Every delivered date has a month from one to twelve and a nonzero day.
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (res.month >= 4'd1) && (res.month <= 4'd12) && (res.day != 5'd0))
    else $error("month or day out of range");

  // Every delivered year lies in the span a 16-bit MJD can reach.
  a_year_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (res.year >= 11'd1900) && (res.year <= 11'd2039))
    else $error("year out of range");

endmodule

// File: design/dvbetd_prep.sv
// First pipeline stage: MJD saturation, scaled year numerator and BCD decode.
// Depends on dvbetd_pkg.
module dvbetd_prep
  import dvbetd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [39:0] event_start,
  input  logic [23:0] duration,
  output logic        out_valid,
  input  logic        out_ready,
  output prep_t       out_data
);

  logic  vld;
  prep_t data;
  prep_t data_next;
  logic [15:0] mjd_raw;
  logic [15:0] mjd_sat;
  logic [20:0] mjd_x20;

  // Stage holds its item until the next stage takes it.
  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign out_data  = data;

  // Saturate early dates, form 20*mjd - 301564 and decode the six time bytes.
  always_comb begin
    mjd_raw = event_start[39:24];
    mjd_sat = (mjd_raw < 16'(MjdFloor)) ? 16'(MjdFloor) : mjd_raw;
    mjd_x20 = ({5'b0, mjd_sat} << 4) + ({5'b0, mjd_sat} << 2);
    data_next.mjd              = mjd_sat;
    data_next.num              = NumW'(mjd_x20 - 21'(YearNumOfs));
    data_next.tod.start_hour   = bcd_dec(event_start[23:16]);
    data_next.tod.start_minute = bcd_dec(event_start[15:8]);
    data_next.tod.start_second = bcd_dec(event_start[7:0]);
    data_next.tod.span_hours   = bcd_dec(duration[23:16]);
    data_next.tod.span_minutes = bcd_dec(duration[15:8]);
    data_next.tod.span_seconds = bcd_dec(duration[7:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

endmodule

// File: design/dvbetd_year.sv
// Second and third pipeline stages: year index by reciprocal multiply, then the
// day remainder inside the year. Depends on dvbetd_pkg.
module dvbetd_year
  import dvbetd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  prep_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output yrem_t out_data
);

  logic  vld2;
  logic  vld3;
  logic  rdy2;
  logic  rdy3;
  yidx_t s2;
  yidx_t s2_next;
  yrem_t s3;
  yrem_t s3_next;
  logic [ProdW-1:0] prod;
  logic [17:0]      yp_x1461;
  logic [15:0]      a;
  logic [16:0]      rem;

  assign rdy3      = !vld3 || out_ready;
  assign rdy2      = !vld2 || rdy3;
  assign in_ready  = rdy2;
  assign out_valid = vld3;
  assign out_data  = s3;

  // Year index: floor(num / 7305) as a multiply by the scaled reciprocal.
  always_comb begin
    prod        = ProdW'(in_data.num) * ProdW'(YearRecip);
    s2_next.mjd = in_data.mjd;
    s2_next.yp  = prod[YearShift +: YpW];
    s2_next.tod = in_data.tod;
  end

  // Remainder: mjd - 14956 - floor(Y' * 365.25).
  always_comb begin
    yp_x1461   = 18'(s2.yp) * 18'd1461;
    a          = yp_x1461[17:2];
    rem        = {1'b0, s2.mjd} - 17'(MjdOfs) - {1'b0, a};
    s3_next.yp  = s2.yp;
    s3_next.r   = rem[RW-1:0];
    s3_next.tod = s2.tod;
  end

  // Valid bits of both stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
      vld3 <= 1'b0;
    end else begin
      if (rdy2) begin
        vld2 <= in_valid;
      end
      if (rdy3) begin
        vld3 <= vld2;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (rdy2 && in_valid) begin
      s2 <= s2_next;
    end
    if (rdy3 && vld2) begin
      s3 <= s3_next;
    end
  end

endmodule

// File: design/dvbetd_month.sv
// Fourth and fifth pipeline stages: month index by threshold compare, then day,
// month and year with the January/February correction. Depends on dvbetd_pkg.
module dvbetd_month
  import dvbetd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  yrem_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_data
);

  localparam mtab_t MonthThr  = mk_mthr();
  localparam mtab_t MonthDays = mk_mdays();

  logic  vld4;
  logic  vld5;
  logic  rdy4;
  logic  rdy5;
  midx_t s4;
  midx_t s4_next;
  res_t  s5;
  res_t  s5_next;
  logic [MpN-2:0] thermo;
  logic [RW-1:0]  dd;
  logic           k;

  assign rdy5      = !vld5 || out_ready;
  assign rdy4      = !vld4 || rdy5;
  assign in_ready  = rdy4;
  assign out_valid = vld5;
  assign out_data  = s5;

  // M' counts the thresholds that the remainder reaches; they rise monotonically.
  always_comb begin
    for (int i = 1; i < MpN; i++) begin
      thermo[i-1] = (in_data.r >= MonthThr[i]);
    end
    s4_next.yp  = in_data.yp;
    s4_next.r   = in_data.r;
    s4_next.mp  = MpW'($countones(thermo));
    s4_next.tod = in_data.tod;
  end

  // Day from the month table; months 14 and 15 roll into the next year.
  always_comb begin
    dd            = s4.r - MonthDays[s4.mp];
    k             = (s4.mp == MpW'(14)) || (s4.mp == MpW'(15));
    s5_next.year  = 11'(s4.yp) + 11'(k) + 11'(YearBase);
    s5_next.month = 4'(s4.mp - MpW'(1) - (k ? MpW'(12) : MpW'(0)));
    s5_next.day   = dd[4:0];
    s5_next.tod   = s4.tod;
  end

  // Valid bits of both stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld4 <= 1'b0;
      vld5 <= 1'b0;
    end else begin
      if (rdy4) begin
        vld4 <= in_valid;
      end
      if (rdy5) begin
        vld5 <= vld4;
      end
    end
  end

  // Payload registers; the last one is the output register.
  always_ff @(posedge clk) begin
    if (rdy4 && in_valid) begin
      s4 <= s4_next;
    end
    if (rdy5 && vld4) begin
      s5 <= s5_next;
    end
  end

endmodule

// File: bench/dvb_event_time_decode_core_tb.sv
// Self-checking testbench for dvb_event_time_decode_core: streams event times in,
// predicts calendar date and decoded time bytes, and checks every output transfer.
// Depends only on the decoder RTL.
module dvb_event_time_decode_core_tb;

  // Date conversion constants of the broadcast MJD formulas, scaled to integers.
  localparam int unsigned MJD_MIN       = 15079;
  localparam int unsigned YEAR_OFS_X20  = 301564;
  localparam int unsigned DAYS_X20      = 7305;
  localparam int unsigned MJD_BASE      = 14956;
  localparam int unsigned MONTH_X10K    = 306001;
  localparam int unsigned MONTH_BIAS    = 1000;
  localparam int unsigned BASE_YEAR     = 1900;

  // Run control.
  localparam int RANDOM_ITEMS   = 1500;
  localparam int HOLDOFF_AT     = 400;   // input transfers before the long output stall
  localparam int HOLDOFF_CYCLES = 300;
  localparam int DRAIN_CYCLES   = 20;    // pipeline is five stages deep
  localparam int IDLE_LIMIT     = 2000;

  typedef struct {
    logic [39:0] event_start;
    logic [23:0] duration;
  } event_in_t;

  typedef struct {
    logic [10:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [7:0]  start_hour;
    logic [7:0]  start_minute;
    logic [7:0]  start_second;
    logic [7:0]  span_hours;
    logic [7:0]  span_minutes;
    logic [7:0]  span_seconds;
  } decoded_time_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [39:0] event_start, [63:40] duration
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [10:0] year, [14:11] month, [19:15] day, [27:20] start_hour,
  // [35:28] start_minute, [43:36] start_second, [51:44] span_hours,
  // [59:52] span_minutes, [67:60] span_seconds, [71:68] zero
  logic [71:0] m_axis_tdata;

  event_in_t     pending_events[$];
  decoded_time_t expected_decodes[$];
  int            fail_count = 0;
  int            sent_count = 0;
  int            idle_cycles = 0;

  dvb_event_time_decode_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk = ~clk;

  // Packed BCD byte to binary; digits above nine pass through unchecked.
  function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
    return 8'(b[7:4] * 10 + b[3:0]);
  endfunction

  // Calendar date from the MJD plus the six decoded time bytes.
  function automatic decoded_time_t decode_event_time(input event_in_t ev);
    int unsigned   mjd, years, year_days, month_idx, month_days, wrap;
    decoded_time_t r;
    mjd = ev.event_start[39:24];
    if (mjd < MJD_MIN) mjd = MJD_MIN;
    years      = (20 * mjd - YEAR_OFS_X20) / DAYS_X20;
    year_days  = (years * 1461) / 4;
    month_idx  = (10000 * (mjd - MJD_BASE - year_days) - MONTH_BIAS) / MONTH_X10K;
    month_days = (month_idx * MONTH_X10K) / 10000;
    // January and February count as months 13 and 14 of the previous year.
    wrap = (month_idx == 14 || month_idx == 15) ? 1 : 0;
    r.year         = 11'(years + wrap + BASE_YEAR);
    r.month        = 4'(month_idx - 1 - 12 * wrap);
    r.day          = 5'(mjd - MJD_BASE - year_days - month_days);
    r.start_hour   = bcd_to_bin(ev.event_start[23:16]);
    r.start_minute = bcd_to_bin(ev.event_start[15:8]);
    r.start_second = bcd_to_bin(ev.event_start[7:0]);
    r.span_hours   = bcd_to_bin(ev.duration[23:16]);
    r.span_minutes = bcd_to_bin(ev.duration[15:8]);
    r.span_seconds = bcd_to_bin(ev.duration[7:0]);
    return r;
  endfunction

  task automatic add_event(input logic [15:0] mjd, input logic [23:0] tod,
                           input logic [23:0] span);
    event_in_t ev;
    ev.event_start = {mjd, tod};
    ev.duration    = span;
    pending_events.push_back(ev);
  endtask

  // Mostly valid BCD bytes, with raw bytes mixed in to hit nibbles above nine.
  function automatic logic [7:0] rand_time_byte();
    if ($urandom_range(0, 9) < 7) begin
      return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
    end
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] rand_mjd();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(14900, 15500));
      2: return 16'($urandom_range(40000, 65535));
      default: return 16'($urandom_range(MJD_MIN, 65535));
    endcase
  endfunction

  task automatic compare_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
      fail_count++;
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 1;
  int gap_left = 0;
  bit send_next;
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_decodes.push_back(decode_event_time(pending_events.pop_front()));
        sent_count++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
        end
      end
      send_next = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_events.size() != 0) begin
        send_next = 1'b1;
      end
      s_axis_tvalid <= send_next;
      if (send_next) begin
        s_axis_tdata <= {pending_events[0].duration, pending_events[0].event_start};
      end
    end
  end

  // Receiver: stall pattern drawn from four modes at regular intervals, plus one long hold-off.
  int  rx_cycle = 0;
  int  stall_mode = 0;
  int  holdoff_left = 0;
  bit  holdoff_done = 1'b0;
  bit  ready_next;
  decoded_time_t want;
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_decodes.size() == 0) begin
          $display("%0t: output transfer with no result expected, got %h",
                   $time, m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_decodes.pop_front();
          compare_field("year",         want.year,         m_axis_tdata[10:0]);
          compare_field("month",        want.month,        m_axis_tdata[14:11]);
          compare_field("day",          want.day,          m_axis_tdata[19:15]);
          compare_field("start_hour",   want.start_hour,   m_axis_tdata[27:20]);
          compare_field("start_minute", want.start_minute, m_axis_tdata[35:28]);
          compare_field("start_second", want.start_second, m_axis_tdata[43:36]);
          compare_field("span_hours",   want.span_hours,   m_axis_tdata[51:44]);
          compare_field("span_minutes", want.span_minutes, m_axis_tdata[59:52]);
          compare_field("span_seconds", want.span_seconds, m_axis_tdata[67:60]);
        end
      end
      rx_cycle++;
      if (rx_cycle % 64 == 0) stall_mode = $urandom_range(0, 3);
      if (!holdoff_done && sent_count >= HOLDOFF_AT) begin
        holdoff_done = 1'b1;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        ready_next = 1'b0;
      end else begin
        case (stall_mode)
          0: ready_next = 1'b1;
          1: ready_next = ($urandom_range(0, 3) != 0);
          2: ready_next = ($urandom_range(0, 3) == 0);
          default: ready_next = rx_cycle[0];
        endcase
      end
      m_axis_tready <= ready_next;
    end
  end

  // Count cycles with no transfer on either side.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
    $display("dvb_event_time_decode_core verification failed");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    // Directed: saturation edge, year and leap boundaries, field extremes.
    add_event(16'd0,     24'h000000, 24'h000000);
    add_event(16'd15078, 24'h235959, 24'h995959);
    add_event(16'd15079, 24'h000000, 24'h000001);
    add_event(16'd15080, 24'hFFFFFF, 24'hFFFFFF);
    add_event(16'd15384, 24'h99AAFF, 24'hAA5500);
    add_event(16'd15385, 24'h5555AA, 24'h0F0F0F);
    add_event(16'd15444, 24'hF0F0F0, 24'hF0F0F0);
    add_event(16'd15750, 24'h123456, 24'h654321);
    add_event(16'd51543, 24'h235959, 24'h000100);
    add_event(16'd51544, 24'h000000, 24'h010000);
    add_event(16'd51603, 24'h120000, 24'h003000);
    add_event(16'd51604, 24'h090909, 24'h090909);
    add_event(16'd51909, 24'h1A2B3C, 24'h4D5E6F);
    add_event(16'd51910, 24'h0A0A0A, 24'hA0A0A0);
    add_event(16'd58849, 24'h200000, 24'h013000);
    add_event(16'd32768, 24'h800000, 24'h000080);
    add_event(16'd32767, 24'h7F7F7F, 24'h7F7F7F);
    add_event(16'd65534, 24'h010203, 24'h040506);
    add_event(16'd65535, 24'hFFFFFF, 24'h000000);
    add_event(16'd65535, 24'h000000, 24'hFFFFFF);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      add_event(rand_mjd(), {rand_time_byte(), rand_time_byte(), rand_time_byte()},
                {rand_time_byte(), rand_time_byte(), rand_time_byte()});
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (pending_events.size() != 0 || expected_decodes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("dvb_event_time_decode_core verification clean");
    end else begin
      $display("dvb_event_time_decode_core verification failed");
    end
    $finish;
  end

endmodule
